FILE: hdl/lpht_pkg.sv
// Shared types and constants for the linear-probing hash table.
package lpht_pkg;

	// Operation codes on the kind input
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_LOOKUP = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;
	localparam logic [1:0] KIND_RSVD   = 2'd3;

	// Result status codes
	localparam logic [2:0] STATUS_INSERTED  = 3'd0;
	localparam logic [2:0] STATUS_DUPLICATE = 3'd1;
	localparam logic [2:0] STATUS_FOUND     = 3'd2;
	localparam logic [2:0] STATUS_NOT_FOUND = 3'd3;
	localparam logic [2:0] STATUS_FULL      = 3'd4;
	localparam logic [2:0] STATUS_CLEARED   = 3'd5;
	localparam logic [2:0] STATUS_INVALID   = 3'd6;

	// Configuration register indexes
	localparam logic REG_USED_ADDR_BITS = 1'b0;

	// Field widths
	localparam int KEY_HEAD_W = 64;
	localparam int KEY_TAIL_W = 32;
	localparam int VALUE_W    = 32;
	localparam int COUNT_W    = 17;
	localparam int USED_W     = 5;
	localparam int ENTRY_W    = KEY_HEAD_W + KEY_TAIL_W + VALUE_W;

	localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};
	localparam logic [USED_W-1:0]  USED_RESET    = 5'd16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_SWEEP
	} lpht_state_t;

	// One slot of the table as held in the slot store
	typedef struct packed {
		logic [KEY_HEAD_W-1:0] key_head;
		logic [KEY_TAIL_W-1:0] key_tail;
		logic [VALUE_W-1:0]    value;
	} lpht_entry_t;

endpackage

FILE: hdl/lpht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lpht_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, read data registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/linear_probe_hash_table_top.sv
// Top level of the linear-probing hash table: control, probe sequencer and register port.
//
// Usage:
//   Commands enter on start/kind/key_head/key_tail/entry_value and are taken at a
//   rising edge where start is high and busy is low. Each command gives exactly one
//   result on status/found_value/entry_count, marked by a one-cycle done strobe.
//   The receiver cannot stall; a result must be taken in its strobe cycle.
//   Insert and lookup walk the slot store one slot per cycle through its single
//   read port. A command with an illegal kind or a zero insert value answers in the
//   cycle after it is taken. Clear sweeps the whole slot store one slot per cycle,
//   then answers. After reset the same sweep runs with busy high; no result is
//   given for it. The used_addr_bits register sits at byte address 0 of the APB
//   port; the user must write it only while the block is idle, and the block
//   itself does not enforce this.
module linear_probe_hash_table_top import lpht_pkg::*; #(
	parameter int SLOT_ADDR_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command transaction
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            kind,
	input  logic [KEY_HEAD_W-1:0] key_head,
	input  logic [KEY_TAIL_W-1:0] key_tail,
	input  logic [VALUE_W-1:0]    entry_value,
	// result transaction
	output logic                  done,
	output logic [2:0]            status,
	output logic [VALUE_W-1:0]    found_value,
	output logic [COUNT_W-1:0]    entry_count,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int AW        = SLOT_ADDR_BITS;
	localparam int RAM_DEPTH = 2 ** SLOT_ADDR_BITS;

	lpht_state_t           state_q, state_d;
	logic [AW-1:0]         home_q, addr_q, sweep_q;
	logic [1:0]            kind_q;
	logic [KEY_HEAD_W-1:0] head_q;
	logic [KEY_TAIL_W-1:0] tail_q;
	logic [VALUE_W-1:0]    value_q;
	logic                  clearing_q;
	logic [COUNT_W-1:0]    count_q;
	logic [USED_W-1:0]     used_q;
	logic                  done_q;
	logic [2:0]            status_q;
	logic [VALUE_W-1:0]    found_q;

	logic                  accept;
	logic                  cmd_invalid;
	logic [USED_W-1:0]     live_bits;
	logic [AW-1:0]         mask;
	logic [AW-1:0]         home;
	logic [AW-1:0]         next_addr;
	lpht_entry_t           rd_entry, wr_entry;
	logic                  slot_empty, slot_hit, wrapped;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic                  res_valid;
	logic [2:0]            res_status;
	logic [VALUE_W-1:0]    res_found;
	logic                  cnt_inc, cnt_clr;
	logic                  cfg_write;

	// Configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_USED_ADDR_BITS);
	assign prdata    = (paddr[2] == REG_USED_ADDR_BITS) ? {{(32-USED_W){1'b0}}, used_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= USED_RESET;
		end else if (cfg_write) begin
			used_q <= pwdata[USED_W-1:0];
		end
	end

	// Saturate the register to 1..SLOT_ADDR_BITS and build the slot mask
	always_comb begin
		live_bits = used_q;
		if (used_q == '0) begin
			live_bits = USED_W'(1);
		end else if (used_q > USED_W'(SLOT_ADDR_BITS)) begin
			live_bits = USED_W'(SLOT_ADDR_BITS);
		end
	end

	assign mask      = {AW{1'b1}} >> (USED_W'(AW) - live_bits);
	assign home      = key_head[AW-1:0] & mask;
	assign next_addr = (addr_q + AW'(1)) & mask;

	assign accept      = start && !busy;
	assign cmd_invalid = (kind == KIND_RSVD) ||
	                     ((kind == KIND_INSERT) && (entry_value == '0));

	// Slot store
	lpht_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (RAM_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.raddr (ram_raddr),
		.rdata (rd_entry)
	);

	// Compare the slot just read against the held key
	assign slot_empty = (rd_entry.value == '0);
	assign slot_hit   = !slot_empty && (rd_entry.key_head == head_q) &&
	                    (rd_entry.key_tail == tail_q);
	assign wrapped    = (next_addr == home_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !cmd_invalid) begin
					state_d = (kind == KIND_CLEAR) ? ST_SWEEP : ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (slot_empty || slot_hit || wrapped) begin
					state_d = ST_IDLE;
				end
			end
			ST_SWEEP: begin
				if (&sweep_q) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory access and result decisions
	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = addr_q;
		ram_raddr  = addr_q;
		wr_entry   = '{key_head: head_q, key_tail: tail_q, value: value_q};
		res_valid  = 1'b0;
		res_status = STATUS_INVALID;
		res_found  = '0;
		cnt_inc    = 1'b0;
		cnt_clr    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ram_raddr = home;
				if (accept && cmd_invalid) begin
					res_valid = 1'b1;
				end
			end
			ST_PROBE: begin
				ram_raddr = next_addr;
				if (slot_hit) begin
					res_valid  = 1'b1;
					res_status = (kind_q == KIND_INSERT) ? STATUS_DUPLICATE : STATUS_FOUND;
					res_found  = (kind_q == KIND_INSERT) ? '0 : rd_entry.value;
				end else if (slot_empty) begin
					res_valid = 1'b1;
					if (kind_q == KIND_INSERT) begin
						ram_we     = 1'b1;
						cnt_inc    = 1'b1;
						res_status = STATUS_INSERTED;
					end else begin
						res_status = STATUS_NOT_FOUND;
					end
				end else if (wrapped) begin
					res_valid  = 1'b1;
					res_status = (kind_q == KIND_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
				end
			end
			ST_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_q;
				wr_entry  = '{key_head: head_q, key_tail: tail_q, value: '0};
				if (&sweep_q) begin
					cnt_clr    = 1'b1;
					res_valid  = clearing_q;
					res_status = STATUS_CLEARED;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_SWEEP;
			sweep_q    <= '0;
			clearing_q <= 1'b0;
			count_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_valid;
			if (state_q == ST_SWEEP) begin
				sweep_q <= sweep_q + AW'(1);
			end
			if (accept) begin
				clearing_q <= (kind == KIND_CLEAR);
			end
			if (cnt_clr) begin
				count_q <= '0;
			end else if (cnt_inc && (count_q != COUNT_MAX)) begin
				count_q <= count_q + COUNT_W'(1);
			end
		end
	end

	// Command and probe payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= kind;
			head_q  <= key_head;
			tail_q  <= key_tail;
			value_q <= entry_value;
			home_q  <= home;
			addr_q  <= home;
		end else if (state_q == ST_PROBE) begin
			addr_q <= next_addr;
		end
		if (res_valid) begin
			status_q <= res_status;
			found_q  <= res_found;
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign found_value = found_q;
	assign entry_count = count_q;

	// Every accepted command is either still running or answered next cycle
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done))
		else $error("accepted command neither running nor answered");

	// A found result always carries a live value
	a_found_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STATUS_FOUND)) |-> (found_value != '0))
		else $error("found result with empty value");

	// A successful insert wrote the slot store on the deciding edge
	a_insert_wrote: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STATUS_INSERTED)) |-> $past(ram_we))
		else $error("insert reported without a slot write");

	// Clear leaves the table empty
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STATUS_CLEARED)) |-> (entry_count == '0))
		else $error("clear reported with entries left");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the linear-probing hash table: driver, monitor, predictor.
`timescale 1ns / 1ps

module tb import lpht_pkg::*; ();

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 12;
	localparam int SLOT_BITS    = 16;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int DRAIN_LIMIT  = 200_000;
	localparam int SETTLE       = 4;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 81;
	localparam int POOL_DEPTH   = 48;
	localparam logic [2:0] USED_BITS_ADDR = 3'(4 * REG_USED_ADDR_BITS);

	typedef struct {
		logic [1:0]            op;
		logic [KEY_HEAD_W-1:0] head;
		logic [KEY_TAIL_W-1:0] tail;
		logic [VALUE_W-1:0]    value;
	} table_cmd_t;

	typedef struct {
		logic [1:0]         op;
		logic [2:0]         status;
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] count;
	} table_result_t;

	typedef struct packed {
		logic [KEY_HEAD_W-1:0] head;
		logic [KEY_TAIL_W-1:0] tail;
	} table_key_t;

	// DUT ports
	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  start       = 1'b0;
	logic                  busy;
	logic [1:0]            kind        = KIND_LOOKUP;
	logic [KEY_HEAD_W-1:0] key_head    = '0;
	logic [KEY_TAIL_W-1:0] key_tail    = '0;
	logic [VALUE_W-1:0]    entry_value = '0;
	logic                  done;
	logic [2:0]            status;
	logic [VALUE_W-1:0]    found_value;
	logic [COUNT_W-1:0]    entry_count;
	logic                  psel        = 1'b0;
	logic                  penable     = 1'b0;
	logic                  pwrite      = 1'b0;
	logic [2:0]            paddr       = '0;
	logic [31:0]           pwdata      = '0;
	logic [31:0]           prdata;
	logic                  pready;

	// Predictor state: slot stores, entry count, register copy
	logic [KEY_HEAD_W-1:0] tbl_head  [int unsigned];
	logic [KEY_TAIL_W-1:0] tbl_tail  [int unsigned];
	logic [VALUE_W-1:0]    tbl_value [int unsigned];
	logic [COUNT_W-1:0]    tbl_count     = '0;
	logic [USED_W-1:0]     cfg_used_bits = USED_RESET;

	table_cmd_t    pending_cmds[$];
	table_result_t expected_results[$];
	table_key_t    key_pool[$];
	logic [15:0]   cluster_base = '0;
	bit            steady_run   = 1'b0;
	int unsigned   mismatch_count = 0;
	int unsigned   cycle_count    = 0;

	linear_probe_hash_table_top #(
		.SLOT_ADDR_BITS(SLOT_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.key_head(key_head),
		.key_tail(key_tail),
		.entry_value(entry_value),
		.done(done),
		.status(status),
		.found_value(found_value),
		.entry_count(entry_count),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	// Apply one command to the table copy and return the result it must give
	function automatic table_result_t table_predict(input logic [1:0] op,
			input logic [KEY_HEAD_W-1:0] h, input logic [KEY_TAIL_W-1:0] t,
			input logic [VALUE_W-1:0] v);
		table_result_t r;
		int unsigned   live;
		int unsigned   mask;
		int unsigned   idx;
		int unsigned   n;
		bit            hit;
		bit            empty;
		r.op     = op;
		r.status = STATUS_INVALID;
		r.value  = '0;
		live = cfg_used_bits;
		if (live < 1)
			live = 1;
		if (live > SLOT_BITS)
			live = SLOT_BITS;
		mask  = (1 << live) - 1;
		idx   = h[31:0] & mask;
		hit   = 1'b0;
		empty = 1'b0;
		n     = 0;
		// walk forward from the home slot, wrapping within the live slots
		while (n <= mask && !hit && !empty) begin
			if (!tbl_value.exists(idx) || tbl_value[idx] == '0)
				empty = 1'b1;
			else if (tbl_head[idx] == h && tbl_tail[idx] == t)
				hit = 1'b1;
			else begin
				idx = (idx + 1) & mask;
				n++;
			end
		end
		case (op)
			KIND_INSERT: begin
				if (v == '0)
					r.status = STATUS_INVALID;
				else if (hit)
					r.status = STATUS_DUPLICATE;
				else if (!empty)
					r.status = STATUS_FULL;
				else begin
					tbl_head[idx]  = h;
					tbl_tail[idx]  = t;
					tbl_value[idx] = v;
					if (tbl_count != COUNT_MAX)
						tbl_count++;
					r.status = STATUS_INSERTED;
				end
			end
			KIND_LOOKUP: begin
				if (hit) begin
					r.status = STATUS_FOUND;
					r.value  = tbl_value[idx];
				end else
					r.status = STATUS_NOT_FOUND;
			end
			KIND_CLEAR: begin
				tbl_value.delete();
				tbl_count = '0;
				r.status  = STATUS_CLEARED;
			end
			default: r.status = STATUS_INVALID;
		endcase
		r.count = tbl_count;
		return r;
	endfunction

	function automatic void push_cmd(input logic [1:0] op, input logic [KEY_HEAD_W-1:0] h,
			input logic [KEY_TAIL_W-1:0] t, input logic [VALUE_W-1:0] v);
		table_cmd_t c;
		c.op    = op;
		c.head  = h;
		c.tail  = t;
		c.value = v;
		pending_cmds.insert(pending_cmds.size(), c);
	endfunction

	function automatic table_key_t fresh_key();
		table_key_t k;
		k.head = {$urandom, $urandom};
		k.tail = $urandom;
		// pile half the keys onto a few neighbouring home slots to grow clusters
		if ($urandom_range(1) != 0)
			k.head[15:0] = cluster_base + 16'($urandom_range(3));
		return k;
	endfunction

	function automatic table_cmd_t random_cmd();
		table_cmd_t  c;
		table_key_t  k;
		int unsigned pick;
		pick    = $urandom_range(99);
		k       = fresh_key();
		c.op    = KIND_INSERT;
		c.value = $urandom;
		if (c.value == '0)
			c.value = 1;
		if ($urandom_range(15) == 0)
			c.value = '1;
		if (pick >= 94 && pick < 97) begin
			c.op = KIND_RSVD;
		end else if (pick < 40 || pick >= 97 || key_pool.size() == 0) begin
			// take a fresh key, inserted unless a lookup was picked, and remember it for later hits
			if (pick >= 54 && pick < 94)
				c.op = KIND_LOOKUP;
			key_pool.insert(key_pool.size(), k);
			if (key_pool.size() > POOL_DEPTH)
				void'(key_pool.pop_front());
		end else if (pick < 50) begin
			k = key_pool[$urandom_range(key_pool.size() - 1)];
		end else if (pick < 54) begin
			c.value = '0;
		end else if (pick < 84) begin
			c.op = KIND_LOOKUP;
			k = key_pool[$urandom_range(key_pool.size() - 1)];
		end else begin
			// miss, often on a stored head with another tail
			c.op = KIND_LOOKUP;
			if ($urandom_range(1) != 0)
				k.head = key_pool[$urandom_range(key_pool.size() - 1)].head;
		end
		c.head = k.head;
		c.tail = k.tail;
		return c;
	endfunction

	// Hold until no command is queued, in flight or owed a result
	task automatic wait_idle();
		@(negedge clk);
		while (pending_cmds.size() != 0 || start || busy || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write used_addr_bits over the register port, then read it back
	task automatic write_used_bits(input logic [USED_W-1:0] bits);
		logic [31:0] word;
		word = $urandom;
		word[USED_W-1:0] = bits;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= USED_BITS_ADDR;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		cfg_used_bits = bits;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== 32'(bits))
			report_mismatch($sformatf("register read %0h, want %0h", prdata, bits));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Driver: offer the next queued command, hold it until taken
	always @(posedge clk) begin : cmd_driver
		table_cmd_t nxt;
		if (!arst_n)
			start <= 1'b0;
		else begin
			if (start && !busy)
				expected_results.insert(expected_results.size(),
					table_predict(kind, key_head, key_tail, entry_value));
			if (!start || !busy) begin
				if (pending_cmds.size() != 0 && (steady_run || $urandom_range(99) >= 16)) begin
					nxt = pending_cmds.pop_front();
					start       <= 1'b1;
					kind        <= nxt.op;
					key_head    <= nxt.head;
					key_tail    <= nxt.tail;
					entry_value <= nxt.value;
				end else
					start <= 1'b0;
			end
		end
	end

	// Monitor: compare each result transaction with the oldest expectation
	always @(posedge clk) begin : result_check
		table_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0)
				report_mismatch($sformatf("result with nothing pending, status %0d", status));
			else begin
				want = expected_results.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("op %0d status %0d, want %0d",
						want.op, status, want.status));
				if (found_value !== want.value)
					report_mismatch($sformatf("op %0d found_value %0h, want %0h",
						want.op, found_value, want.value));
				if (entry_count !== want.count)
					report_mismatch($sformatf("op %0d entry_count %0d, want %0d",
						want.op, entry_count, want.count));
			end
		end
	end

	// Timeout
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		logic [USED_W-1:0] phase_bits [PHASES];
		bit                phase_clear [PHASES];
		int unsigned       phase;
		int unsigned       n;

		phase_bits  = '{5'd4, 5'd2, 5'd16, 5'd20, 5'd7, 5'd3, 5'd10, 5'd5};
		phase_clear = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

		// Directed: full-width table straight after reset
		push_cmd(KIND_LOOKUP, '1, '1, '0);
		push_cmd(KIND_INSERT, '1, '1, '0);
		push_cmd(KIND_INSERT, '1, '1, '1);
		push_cmd(KIND_INSERT, '0, '0, 32'd1);
		push_cmd(KIND_INSERT, '1, '1, 32'd5);
		push_cmd(KIND_LOOKUP, '1, '1, '0);
		// same head, other tail: probe wraps from the top slot past slot zero
		push_cmd(KIND_INSERT, '1, '0, 32'h8000_0000);
		push_cmd(KIND_LOOKUP, '1, '0, '0);
		push_cmd(KIND_LOOKUP, '1, 32'd1, '0);
		push_cmd(KIND_INSERT, 64'h8000_0000_0000_0000, '0, 32'd2);
		push_cmd(KIND_LOOKUP, '0, '0, '0);
		push_cmd(KIND_RSVD, {$urandom, $urandom}, $urandom, $urandom);
		push_cmd(KIND_CLEAR, '0, '0, '0);
		push_cmd(KIND_LOOKUP, '1, '1, '0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();

		// Two live slots: fill, overflow, miss in a full table
		write_used_bits(5'd1);
		push_cmd(KIND_INSERT, 64'h5555_5555_5555_5554, 32'h1234_5678, 32'h0000_0010);
		push_cmd(KIND_INSERT, 64'hAAAA_AAAA_AAAA_0001, 32'h8765_4321, 32'h0000_0020);
		push_cmd(KIND_INSERT, 64'h0F0F_0F0F_0F0F_0F0E, 32'hCAFE_0000, 32'h0000_0030);
		push_cmd(KIND_LOOKUP, 64'h0F0F_0F0F_0F0F_0F0E, 32'hCAFE_0000, '0);
		push_cmd(KIND_LOOKUP, 64'hAAAA_AAAA_AAAA_0001, 32'h8765_4321, '0);
		push_cmd(KIND_INSERT, 64'h5555_5555_5555_5554, 32'h1234_5678, 32'h0000_0040);
		push_cmd(KIND_INSERT, 64'h0123_4567_89AB_CDEF, 32'h0, '0);
		wait_idle();

		// Below range: saturates to one live slot bit
		write_used_bits(5'd0);
		push_cmd(KIND_LOOKUP, 64'h5555_5555_5555_5554, 32'h1234_5678, '0);
		wait_idle();

		// Above range with entries in place: probes take the wider mask
		write_used_bits(5'd31);
		push_cmd(KIND_LOOKUP, 64'hAAAA_AAAA_AAAA_0001, 32'h8765_4321, '0);
		push_cmd(KIND_INSERT, 64'h3C3C_3C3C_3C3C_0002, 32'h0BAD_F00D, 32'h7FFF_FFFF);
		push_cmd(KIND_LOOKUP, 64'h0F0F_0F0F_0F0F_0F0E, 32'hCAFE_0000, '0);

		// Random phases, each one writing the table size anew after a full drain
		for (phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			write_used_bits(phase_bits[phase]);
			cluster_base = $urandom;
			steady_run   = (phase == 3);
			key_pool.delete();
			if (phase_clear[phase])
				push_cmd(KIND_CLEAR, {$urandom, $urandom}, $urandom, $urandom);
			for (n = 0; n < PHASE_ITEMS; n++)
				pending_cmds.insert(pending_cmds.size(), random_cmd());
		end

		// Drain, bounded so that a lost result is reported
		@(negedge clk);
		while (pending_cmds.size() != 0 || start)
			@(negedge clk);
		n = 0;
		while (expected_results.size() != 0 && n < DRAIN_LIMIT) begin
			@(negedge clk);
			n++;
		end
		repeat (SETTLE) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
